// File: src/block_buffer_cache_defines.svh
// Assertion macros used by the checker file of the block buffer cache.
`ifndef BLOCK_BUFFER_CACHE_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_DEFINES_SVH

// Check a same-cycle implication, held off during reset.
`define BBC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block buffer cache check failed");

// Check an implication in the following cycle, held off during reset.
`define BBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block buffer cache check failed");

`endif

// File: src/bbc_pkg.sv
package bbc_pkg;

    // Default sizes
    localparam int NUM_SLOTS_DEF  = 8;
    localparam int BLOCK_BITS_DEF = 16;

    // Port field widths
    localparam int REQ_W    = 3;
    localparam int BLKNUM_W = 16;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int WB_W     = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_BLOCK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BUFFER = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SAVE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_EMPTY  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_GRANT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WB    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    // Tag store write controls
    typedef struct packed {
        logic wr;
        logic clr_one;
        logic clr_all;
    } tag_ctl_t;

endpackage

// File: src/bbc_tag_store.sv
module bbc_tag_store #(
    parameter int NUM_SLOTS  = bbc_pkg::NUM_SLOTS_DEF,
    parameter int BLOCK_BITS = bbc_pkg::BLOCK_BITS_DEF,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bbc_pkg::tag_ctl_t     ctl,
    input  logic [SW-1:0]         wr_addr,
    input  logic [BLOCK_BITS-1:0] wr_tag,
    input  logic [SW-1:0]         rd_addr,
    output logic [BLOCK_BITS-1:0] rd_tag
);
    import bbc_pkg::*;

    logic [BLOCK_BITS-1:0] mem [NUM_SLOTS];
    logic [BLOCK_BITS-1:0] q_reg;
    logic                  qv_reg;
    logic [NUM_SLOTS-1:0]  valid_reg;
    logic [NUM_SLOTS-1:0]  valid_next;

    // Write the tag array and register the read word
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_addr] <= wr_tag;
        end
        q_reg <= mem[rd_addr];
    end

    // Track which slots hold a written tag; others read as free
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr_all)
        begin
            valid_next = '0;
        end
        else if (ctl.clr_one)
        begin
            valid_next[wr_addr] = 1'b0;
        end
        else if (ctl.wr)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            qv_reg    <= valid_reg[rd_addr];
        end
    end

    assign rd_tag = qv_reg ? q_reg : '0;

endmodule

// File: src/block_buffer_cache.sv
// Block buffer cache controller: keeps a block tag and a dirty mark for each of
// NUM_SLOTS buffer slots and answers one request at a time; in_stall is high
// while the sequencer is busy with a request, until its last result is loaded
// into the output register. The tags sit in a memory with one registered read
// port: a block or buffer request streams all NUM_SLOTS tags through one compare
// unit, and a dirty victim is written back in a beat of its own before the grant;
// save all and flush all read and then check one slot at a time; update, empty
// all and unknown codes go straight to the done beat. Output stalls hold the
// sequencer. No clearing pass is needed after reset.
module block_buffer_cache #(
    parameter int NUM_SLOTS  = bbc_pkg::NUM_SLOTS_DEF,
    parameter int BLOCK_BITS = bbc_pkg::BLOCK_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bbc_pkg::REQ_W-1:0]    req_type,
    input  logic [bbc_pkg::BLKNUM_W-1:0] block_num,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bbc_pkg::KIND_W-1:0]   kind,
    output logic [bbc_pkg::SLOT_W-1:0]   slot,
    output logic [bbc_pkg::WB_W-1:0]     wb_block,
    output logic                         fetch,
    output logic                         last
);
    import bbc_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int BB = BLOCK_BITS;
    localparam logic [SW-1:0]   LAST_SLOT = SW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0]   CNT_END   = CW'(NUM_SLOTS);
    localparam logic [SW+1:0]   MOD_N     = (SW + 2)'(NUM_SLOTS);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_GRANT  = 3'd3;
    localparam logic [2:0] S_WRD    = 3'd4;
    localparam logic [2:0] S_WEMIT  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [BB-1:0]        blk_reg, blk_next;
    logic [SW-1:0]        sp_reg, sp_next;
    logic [SW-1:0]        cur_reg, cur_next;
    logic [NUM_SLOTS-1:0] dirty_reg, dirty_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [SW-1:0]        paddr_reg, paddr_next;
    logic                 hit_reg, hit_next;
    logic [SW-1:0]        hslot_reg, hslot_next;
    logic                 free_reg, free_next;
    logic [SW-1:0]        fslot_reg, fslot_next;
    logic [BB-1:0]        vtag_reg, vtag_next;

    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [WB_W-1:0]      wb_reg;
    logic                 fetch_reg;
    logic                 last_reg;

    // Result beat to load
    logic                 emit;
    logic [KIND_W-1:0]    e_kind;
    logic [SW-1:0]        e_slot;
    logic [BB-1:0]        e_wb;
    logic                 e_fetch;
    logic                 e_last;

    logic                 out_free;
    logic                 accept;
    logic [BB-1:0]        blk_in;
    logic [BB+BLKNUM_W-1:0] blk_ext;
    logic [SW+SLOT_W-1:0] slot_ext;
    logic [BB+WB_W-1:0]   wb_ext;
    logic [SW+1:0]        scan_sum;
    logic [SW-1:0]        scan_addr;
    logic [SW-1:0]        vic_slot;
    logic [SW-1:0]        walk_idx;
    logic                 walk_need;

    tag_ctl_t             tctl;
    logic [SW-1:0]        t_waddr;
    logic [SW-1:0]        t_raddr;
    logic [BB-1:0]        t_rtag;

    bbc_tag_store #(
        .NUM_SLOTS  (NUM_SLOTS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_tags (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (tctl),
        .wr_addr (t_waddr),
        .wr_tag  (blk_reg),
        .rd_addr (t_raddr),
        .rd_tag  (t_rtag)
    );

    // Fit the block number to the tag width
    assign blk_ext  = {{BB{1'b0}}, block_num};
    assign blk_in   = blk_ext[BB-1:0];

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Scan address: slot after the search pointer, plus the scan count, wrapped
    assign scan_sum  = (SW + 2)'(sp_reg) + (SW + 2)'(1) + (SW + 2)'(cnt_reg[SW-1:0]);
    assign scan_addr = (scan_sum >= MOD_N) ? SW'(scan_sum - MOD_N) : SW'(scan_sum);
    assign vic_slot  = (sp_reg == LAST_SLOT) ? '0 : SW'(sp_reg + SW'(1));
    assign walk_idx  = cnt_reg[SW-1:0];
    assign walk_need = (t_rtag != '0) && dirty_reg[walk_idx];

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        blk_next    = blk_reg;
        sp_next     = sp_reg;
        cur_next    = cur_reg;
        dirty_next  = dirty_reg;
        cnt_next    = cnt_reg;
        pend_next   = 1'b0;
        paddr_next  = paddr_reg;
        hit_next    = hit_reg;
        hslot_next  = hslot_reg;
        free_next   = free_reg;
        fslot_next  = fslot_reg;
        vtag_next   = vtag_reg;
        tctl        = '0;
        t_waddr     = walk_idx;
        t_raddr     = walk_idx;
        emit        = 1'b0;
        e_kind      = KIND_DONE;
        e_slot      = cur_reg;
        e_wb        = '0;
        e_fetch     = 1'b0;
        e_last      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next  = req_type;
                    blk_next  = blk_in;
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    case (req_type)
                        REQ_BLOCK, REQ_BUFFER:
                        begin
                            state_next = S_SCAN;
                        end
                        REQ_UPDATE:
                        begin
                            dirty_next[cur_reg] = 1'b1;
                            state_next = S_DONE;
                        end
                        REQ_SAVE, REQ_FLUSH:
                        begin
                            state_next = S_WRD;
                        end
                        REQ_EMPTY:
                        begin
                            tctl.clr_all = 1'b1;
                            dirty_next   = '0;
                            cur_next     = LAST_SLOT;
                            state_next   = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one tag read per cycle
                t_raddr = scan_addr;
                if (cnt_reg != CNT_END)
                begin
                    pend_next  = 1'b1;
                    paddr_next = scan_addr;
                    cnt_next   = cnt_reg + CW'(1);
                end
                // Compare the tag read last cycle
                if (pend_reg)
                begin
                    if (!hit_reg && t_rtag == blk_reg)
                    begin
                        hit_next   = 1'b1;
                        hslot_next = paddr_reg;
                    end
                    if (!free_reg && t_rtag == '0)
                    begin
                        free_next  = 1'b1;
                        fslot_next = paddr_reg;
                    end
                    if (paddr_reg == vic_slot)
                    begin
                        vtag_next = t_rtag;
                    end
                    if (cnt_reg == CNT_END)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                t_waddr = hit_reg ? hslot_reg : (free_reg ? fslot_reg : vic_slot);
                if (out_free)
                begin
                    emit    = 1'b1;
                    e_kind  = KIND_GRANT;
                    e_slot  = t_waddr;
                    e_fetch = !hit_reg && (req_reg == REQ_BLOCK);
                    sp_next  = t_waddr;
                    cur_next = t_waddr;
                    state_next = S_IDLE;
                    if (!hit_reg)
                    begin
                        tctl.wr = 1'b1;
                        dirty_next[t_waddr] = 1'b0;
                        // Write back a dirty victim before the grant
                        if (!free_reg && vtag_reg != '0 && dirty_reg[vic_slot])
                        begin
                            e_kind     = KIND_WB;
                            e_wb       = vtag_reg;
                            e_fetch    = 1'b0;
                            e_last     = 1'b0;
                            state_next = S_GRANT;
                        end
                    end
                end
            end

            S_GRANT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_GRANT;
                    e_slot     = cur_reg;
                    e_fetch    = (req_reg == REQ_BLOCK);
                    state_next = S_IDLE;
                end
            end

            S_WRD:
            begin
                state_next = S_WEMIT;
            end

            S_WEMIT:
            begin
                if (!walk_need || out_free)
                begin
                    if (walk_need)
                    begin
                        emit   = 1'b1;
                        e_kind = KIND_WB;
                        e_slot = walk_idx;
                        e_wb   = t_rtag;
                        e_last = 1'b0;
                    end
                    cur_next = walk_idx;
                    if (req_reg == REQ_FLUSH)
                    begin
                        tctl.clr_one = 1'b1;
                        dirty_next[walk_idx] = 1'b0;
                    end
                    if (walk_idx == LAST_SLOT)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = S_WRD;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_DONE;
                    e_slot     = cur_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load a new beat, else drop a taken one
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, e_slot};
    assign wb_ext   = {{WB_W{1'b0}}, e_wb};

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= e_kind;
            slot_reg  <= slot_ext[SLOT_W-1:0];
            wb_reg    <= wb_ext[WB_W-1:0];
            fetch_reg <= e_fetch;
            last_reg  <= e_last;
        end
    end

    // Working registers of the current request
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        blk_reg   <= blk_next;
        paddr_reg <= paddr_next;
        hslot_reg <= hslot_next;
        fslot_reg <= fslot_next;
        vtag_reg  <= vtag_next;
    end

    // Control and cache state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            cur_reg       <= '0;
            dirty_reg     <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            cur_reg       <= cur_next;
            dirty_reg     <= dirty_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign slot      = slot_reg;
    assign wb_block  = wb_reg;
    assign fetch     = fetch_reg;
    assign last      = last_reg;

endmodule

// File: src/bbc_checker.sv
`include "block_buffer_cache_defines.svh"

module bbc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [bbc_pkg::REQ_W-1:0]    req_type,
    input logic [bbc_pkg::BLKNUM_W-1:0] block_num,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [bbc_pkg::KIND_W-1:0]   kind,
    input logic [bbc_pkg::SLOT_W-1:0]   slot,
    input logic [bbc_pkg::WB_W-1:0]     wb_block,
    input logic                         fetch,
    input logic                         last
);
    import bbc_pkg::*;

    // All result fields of one beat
    logic [KIND_W+SLOT_W+WB_W+1:0] out_beat;
    assign out_beat = {kind, slot, wb_block, fetch, last};

    // Hold a stalled result beat
    `BBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))

    // Go busy right after taking a request
    `BBC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // A writeback never ends a request and never asks for a fetch
    `BBC_ASSERT_IMPL(a_wb_not_last, out_valid && kind == KIND_WB, !last && !fetch)

    // Grants and done beats end the request and carry no writeback block
    `BBC_ASSERT_IMPL(a_final_beat, out_valid && kind != KIND_WB, last && wb_block == '0)

    // Only a grant asks for a fetch
    `BBC_ASSERT_IMPL(a_fetch_on_grant, out_valid && fetch, kind == KIND_GRANT)

endmodule

bind block_buffer_cache bbc_checker u_bbc_checker (.*);

// File: tb/bbc_checker.sv
module bbc_scoreboard (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [bbc_pkg::REQ_W-1:0]    req_type,
    input  logic [bbc_pkg::BLKNUM_W-1:0] block_num,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [bbc_pkg::KIND_W-1:0]   kind,
    input  logic [bbc_pkg::SLOT_W-1:0]   slot,
    input  logic [bbc_pkg::WB_W-1:0]     wb_block,
    input  logic                         fetch,
    input  logic                         last,
    output int                           mismatches,
    output int                           owed,
    output int                           checked
);
    import bbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = NUM_SLOTS_DEF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [WB_W-1:0]   wb_block;
        logic              fetch;
        logic              last;
    } cache_result_t;

    // Shadow copy of the tag store and its pointers
    logic [BLKNUM_W-1:0] shadow_tag [NUM_SLOTS];
    logic                shadow_dirty [NUM_SLOTS];
    int                  scan_ptr;
    int                  cur_slot;

    cache_result_t       results_due [$];

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_tag[i]   = '0;
            shadow_dirty[i] = 1'b0;
        end
        scan_ptr   = 0;
        cur_slot   = 0;
        mismatches = 0;
        owed       = 0;
        checked    = 0;
    end

    function automatic void owe(input logic [KIND_W-1:0] k, input int s,
                                input logic [WB_W-1:0] wb, input logic f);
        cache_result_t r;
        r.kind     = k;
        r.slot     = s[SLOT_W-1:0];
        r.wb_block = wb;
        r.fetch    = f;
        r.last     = (k != KIND_WB);
        results_due.push_back(r);
    endfunction

    // Round-robin search starting after the scan pointer; -1 on a miss
    function automatic int find_tag(input logic [BLKNUM_W-1:0] t);
        int s;
        s = scan_ptr;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            s = (s + 1) % NUM_SLOTS;
            if (shadow_tag[s] == t)
            begin
                scan_ptr = s;
                cur_slot = s;
                return s;
            end
        end
        return -1;
    endfunction

    function automatic void write_back_if_dirty(input int s);
        cur_slot = s;
        if (shadow_tag[s] != '0 && shadow_dirty[s])
            owe(KIND_WB, s, shadow_tag[s], 1'b0);
    endfunction

    function automatic void retag(input int s, input logic [BLKNUM_W-1:0] t);
        cur_slot        = s;
        shadow_tag[s]   = t;
        shadow_dirty[s] = 1'b0;
    endfunction

    // Advance the shadow state by one request and queue the beats it owes
    function automatic void predict_request(input logic [REQ_W-1:0] rq,
                                            input logic [BLKNUM_W-1:0] bn);
        int   hit;
        int   spare;
        int   s;
        logic miss_fetch;
        miss_fetch = 1'b0;
        if (rq == REQ_BLOCK || rq == REQ_BUFFER)
        begin
            hit = find_tag(bn);
            if (hit >= 0)
                s = hit;
            else
            begin
                spare = find_tag('0);
                if (spare >= 0)
                    s = spare;
                else
                begin
                    scan_ptr = (scan_ptr + 1) % NUM_SLOTS;
                    s = scan_ptr;
                end
                write_back_if_dirty(s);
                retag(s, '0);
                miss_fetch = (rq == REQ_BLOCK);
            end
            if (rq == REQ_BLOCK)
            begin
                if (hit < 0)
                    retag(s, bn);
            end
            else
                shadow_tag[s] = bn;
            owe(KIND_GRANT, s, '0, miss_fetch);
            return;
        end
        case (rq)
            REQ_UPDATE:
                shadow_dirty[cur_slot] = 1'b1;
            REQ_SAVE:
                for (int i = 0; i < NUM_SLOTS; i++)
                    write_back_if_dirty(i);
            REQ_EMPTY:
                for (int i = 0; i < NUM_SLOTS; i++)
                    retag(i, '0);
            REQ_FLUSH:
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    write_back_if_dirty(i);
                    retag(i, '0);
                end
            default:
                ;
        endcase
        owe(KIND_DONE, cur_slot, '0, 1'b0);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Compare each result beat, then fold in each accepted request
    always @(posedge clk)
    begin
        cache_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                checked++;
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, got kind %0d slot %0d wb %0h",
                             $time, kind, slot, wb_block);
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("slot", 32'(want.slot), 32'(slot));
                    check_field("wb_block", 32'(want.wb_block), 32'(wb_block));
                    check_field("fetch", 32'(want.fetch), 32'(fetch));
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            if (in_valid && !in_stall)
                predict_request(req_type, block_num);
            owed = results_due.size();
        end
    end

endmodule

// File: tb/tb.sv
module tb;
    import bbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 360;
    localparam int POOL_SIZE    = 12;

    // Request codes the block does not define
    localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type  = REQ_BLOCK;
    logic [BLKNUM_W-1:0] block_num = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [WB_W-1:0]     wb_block;
    logic                fetch;
    logic                last;

    int  mismatches;
    int  owed;
    int  checked;
    int  cycle_count = 0;
    int  sent_by_code [8];
    bit  quiet = 1'b0;

    block_buffer_cache uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .block_num (block_num),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .slot      (slot),
        .wb_block  (wb_block),
        .fetch     (fetch),
        .last      (last)
    );

    bbc_scoreboard u_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .block_num  (block_num),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .slot       (slot),
        .wb_block   (wb_block),
        .fetch      (fetch),
        .last       (last),
        .mismatches (mismatches),
        .owed       (owed),
        .checked    (checked)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[block_buffer_cache] ERROR");
            $finish;
        end
    end

    // Stall the result channel a random number of cycles before each beat
    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(3);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one request beat after a random gap and hold it until taken
    task automatic send_req(input logic [REQ_W-1:0] rq, input logic [BLKNUM_W-1:0] bn);
        int gap;
        gap = quiet ? 0 : $urandom_range(3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rq;
        block_num <= bn;
        do @(posedge clk); while (in_stall);
        sent_by_code[rq]++;
    endtask

    // Hold off new requests until every owed beat has arrived
    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [BLKNUM_W-1:0] pool [POOL_SIZE];
        logic [BLKNUM_W-1:0] bn;
        logic [REQ_W-1:0]    rq;
        int                  roll;

        for (int c = 0; c < 8; c++)
            sent_by_code[c] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, hits, dirty keep, free-slot match, eviction
        send_req(REQ_BLOCK, 16'hFFFF);
        send_req(REQ_UPDATE, '0);
        send_req(REQ_BUFFER, 16'h8000);
        send_req(REQ_UPDATE, '0);
        send_req(REQ_BLOCK, 16'hFFFF);
        send_req(REQ_BUFFER, 16'h8000);
        send_req(REQ_BLOCK, 16'h0000);
        send_req(REQ_SAVE, '0);
        for (int i = 1; i <= 6; i++)
        begin
            send_req(REQ_BLOCK, 16'(16'h1111 * i));
            send_req(REQ_UPDATE, '0);
        end
        send_req(REQ_BLOCK, 16'h1234);
        send_req(REQ_FLUSH, '0);
        send_req(REQ_UPDATE, '0);
        send_req(REQ_SAVE, '0);
        send_req(REQ_EMPTY, '0);
        send_req(REQ_UNDEF_LO, 16'h5A5A);
        send_req(REQ_UNDEF_HI, '0);

        // Random: mostly requests over a small working set so hits and evictions mix
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 90 == 0)
            begin
                drain_all();
                for (int i = 0; i < POOL_SIZE; i++)
                    pool[i] = 16'($urandom_range(1, 65535));
            end
            quiet = (n >= 150 && n < 190);
            roll = $urandom_range(99);
            if (roll < 80)
                bn = pool[$urandom_range(POOL_SIZE - 1)];
            else if (roll < 85)
                bn = '0;
            else
                bn = 16'($urandom);
            roll = $urandom_range(99);
            if (roll < 35)
                rq = REQ_BLOCK;
            else if (roll < 55)
                rq = REQ_BUFFER;
            else if (roll < 80)
                rq = REQ_UPDATE;
            else if (roll < 86)
                rq = REQ_SAVE;
            else if (roll < 90)
                rq = REQ_FLUSH;
            else if (roll < 94)
                rq = REQ_EMPTY;
            else
                rq = roll[0] ? REQ_UNDEF_HI : REQ_UNDEF_LO;
            if (rq != REQ_BLOCK && rq != REQ_BUFFER && roll % 4 != 0)
                bn = '0;
            send_req(rq, bn);
        end
        quiet = 1'b0;

        // Let the last results drain, then allow for a trailing save
        drain_all();
        repeat (24) @(posedge clk);

        $display("covered %0d block, %0d buffer, %0d update, %0d save, %0d empty, %0d flush,",
                 sent_by_code[REQ_BLOCK], sent_by_code[REQ_BUFFER], sent_by_code[REQ_UPDATE],
                 sent_by_code[REQ_SAVE], sent_by_code[REQ_EMPTY], sent_by_code[REQ_FLUSH]);
        $display("and %0d undefined-code requests; %0d result beats compared",
                 sent_by_code[REQ_UNDEF_LO] + sent_by_code[REQ_UNDEF_HI], checked);
        if (mismatches == 0 && owed == 0)
            $display("[block_buffer_cache] OK");
        else
            $display("[block_buffer_cache] ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/bbc_pkg.sv
src/bbc_tag_store.sv
src/block_buffer_cache.sv
src/bbc_checker.sv
tb/bbc_checker.sv
tb/tb.sv
